// File: rtl/calendar_date_difference_macros.svh
// assertion macros for the calendar date difference block and its checker
// users supply clk and rst_n in the scope where the macros are expanded
`ifndef CALENDAR_DATE_DIFFERENCE_MACROS_SVH
`define CALENDAR_DATE_DIFFERENCE_MACROS_SVH

// property checked outside reset
`define CDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CDD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cdd_pkg.sv
// shared widths, month codes and calendar helper functions
// used by calendar_date_difference and cdd_checker; no dependencies
`default_nettype none

package cdd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;

  // month codes
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  localparam logic [MONTH_W:0] MONTHS_PER_YEAR = 5'd12;

  // divisibility by 25 on a 14-bit year: multiply by the inverse of 25
  // modulo 2**14 and compare against floor((2**14 - 1) / 25)
  localparam logic [YEAR_W-1:0] DIV25_INV    = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_THRESH = 14'd655;

  localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
  localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
  localparam logic [DAY_W-1:0] LEN_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;
  localparam logic [DAY_W-1:0] LEN_NONE  = 5'd0;

  // gregorian leap year rule
  function automatic logic is_leap(input logic [YEAR_W-1:0] year);
    logic [2*YEAR_W-1:0] prod;
    logic                div25;
    prod  = {{YEAR_W{1'b0}}, year} * {{YEAR_W{1'b0}}, DIV25_INV};
    div25 = (prod[YEAR_W-1:0] <= DIV25_THRESH);
    // multiple of 4, and a century year only when also a multiple of 16
    return (year[1:0] == 2'b00) && !(div25 && (year[3:2] != 2'b00));
  endfunction

  // days in a month, zero for a month code outside 1 to 12
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      MON_JAN, MON_MAR, MON_MAY, MON_JUL,
      MON_AUG, MON_OCT, MON_DEC: len = LEN_LONG;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
      MON_FEB: len = leap ? LEN_LEAP : LEN_FEB;
      default: len = LEN_NONE;
    endcase
    return len;
  endfunction

  // full date check
  function automatic logic date_ok(input logic [DAY_W-1:0] day,
                                   input logic [MONTH_W-1:0] month,
                                   input logic [YEAR_W-1:0] year);
    logic [DAY_W-1:0] len;
    len = month_len(month, is_leap(year));
    return (year != '0) && (day != '0) && (day <= len);
  endfunction

endpackage

`default_nettype wire

// File: rtl/calendar_date_difference.sv
// top level: gregorian date validation and elapsed years, months and days
// depends on cdd_pkg
`default_nettype none

// Takes one birth/current date pair per transfer and returns one result per
// pair: a valid flag for each date, an order flag, and the elapsed years,
// months and days (all counts zero on any error). A new pair can be taken
// every cycle while in_stall is low; each result passes through the input
// register and then the result register, with the calendar logic between
// them. in_stall rises only when both registers hold data and the output
// side stalls.
module calendar_date_difference (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cdd_pkg::DAY_W-1:0]     in_birth_day,
  input  wire logic [cdd_pkg::MONTH_W-1:0]   in_birth_month,
  input  wire logic [cdd_pkg::YEAR_W-1:0]    in_birth_year,
  input  wire logic [cdd_pkg::DAY_W-1:0]     in_current_day,
  input  wire logic [cdd_pkg::MONTH_W-1:0]   in_current_month,
  input  wire logic [cdd_pkg::YEAR_W-1:0]    in_current_year,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_birth_valid,
  output logic                               out_current_valid,
  output logic                               out_order_error,
  output logic [cdd_pkg::YEAR_W-1:0]         out_years_elapsed,
  output logic [cdd_pkg::MONTH_W-1:0]        out_months_elapsed,
  output logic [cdd_pkg::DAY_W-1:0]          out_days_elapsed
);

  // input register
  logic                          in_vld_r;
  logic [cdd_pkg::DAY_W-1:0]     bd_r, cd_r;
  logic [cdd_pkg::MONTH_W-1:0]   bm_r, cm_r;
  logic [cdd_pkg::YEAR_W-1:0]    by_r, cy_r;

  // result register
  logic                          res_vld_r;
  logic                          bval_r, cval_r, late_r;
  logic [cdd_pkg::YEAR_W-1:0]    years_r;
  logic [cdd_pkg::MONTH_W-1:0]   months_r;
  logic [cdd_pkg::DAY_W-1:0]     days_r;

  // next values of the result register
  logic                          bval_nxt, cval_nxt, late_nxt;
  logic [cdd_pkg::YEAR_W-1:0]    years_nxt;
  logic [cdd_pkg::MONTH_W-1:0]   months_nxt;
  logic [cdd_pkg::DAY_W-1:0]     days_nxt;

  logic                          res_load;
  logic                          in_load;

  // pipeline advance
  assign res_load = !res_vld_r || !out_stall;
  assign in_load  = !in_vld_r || res_load;
  assign in_stall = !in_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_load) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      bd_r <= in_birth_day;
      bm_r <= in_birth_month;
      by_r <= in_birth_year;
      cd_r <= in_current_day;
      cm_r <= in_current_month;
      cy_r <= in_current_year;
    end
  end

  // validation, order check and differences
  logic                        day_short, year_short;
  logic [cdd_pkg::MONTH_W:0]   mon_diff;
  logic [cdd_pkg::DAY_W:0]     blen;
  logic [cdd_pkg::DAY_W:0]     days_wide;

  always_comb begin
    bval_nxt   = cdd_pkg::date_ok(bd_r, bm_r, by_r);
    cval_nxt   = cdd_pkg::date_ok(cd_r, cm_r, cy_r);
    // lexicographic year, month, day compare on raw fields
    late_nxt   = {by_r, bm_r, bd_r} > {cy_r, cm_r, cd_r};

    day_short  = cd_r < bd_r;
    year_short = (cm_r < bm_r) || ((cm_r == bm_r) && day_short);
    blen       = {1'b0, cdd_pkg::month_len(bm_r, cdd_pkg::is_leap(by_r))};

    if (year_short) begin
      mon_diff = cdd_pkg::MONTHS_PER_YEAR + {1'b0, cm_r} - {1'b0, bm_r};
    end else begin
      mon_diff = {1'b0, cm_r} - {1'b0, bm_r};
    end

    // borrow the remaining days of the birth month
    if (day_short) begin
      days_wide = blen - {1'b0, bd_r} + {1'b0, cd_r};
      mon_diff  = mon_diff - 5'd1;
    end else begin
      days_wide = {1'b0, cd_r} - {1'b0, bd_r};
    end

    if (bval_nxt && cval_nxt && !late_nxt) begin
      years_nxt  = cy_r - by_r - {{(cdd_pkg::YEAR_W-1){1'b0}}, year_short};
      months_nxt = mon_diff[cdd_pkg::MONTH_W-1:0];
      days_nxt   = days_wide[cdd_pkg::DAY_W-1:0];
    end else begin
      years_nxt  = '0;
      months_nxt = '0;
      days_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_load) begin
      res_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && in_vld_r) begin
      bval_r   <= bval_nxt;
      cval_r   <= cval_nxt;
      late_r   <= late_nxt;
      years_r  <= years_nxt;
      months_r <= months_nxt;
      days_r   <= days_nxt;
    end
  end

  // result channel
  assign out_valid          = res_vld_r;
  assign out_birth_valid    = bval_r;
  assign out_current_valid  = cval_r;
  assign out_order_error    = late_r;
  assign out_years_elapsed  = years_r;
  assign out_months_elapsed = months_r;
  assign out_days_elapsed   = days_r;

endmodule

`default_nettype wire

// File: rtl/cdd_checker.sv
// port-level checker for calendar_date_difference, attached by bind
// depends on cdd_pkg and calendar_date_difference_macros.svh
`default_nettype none

`include "calendar_date_difference_macros.svh"

module cdd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [cdd_pkg::DAY_W-1:0]     in_birth_day,
  input wire logic [cdd_pkg::MONTH_W-1:0]   in_birth_month,
  input wire logic [cdd_pkg::YEAR_W-1:0]    in_birth_year,
  input wire logic [cdd_pkg::DAY_W-1:0]     in_current_day,
  input wire logic [cdd_pkg::MONTH_W-1:0]   in_current_month,
  input wire logic [cdd_pkg::YEAR_W-1:0]    in_current_year,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_birth_valid,
  input wire logic                          out_current_valid,
  input wire logic                          out_order_error,
  input wire logic [cdd_pkg::YEAR_W-1:0]    out_years_elapsed,
  input wire logic [cdd_pkg::MONTH_W-1:0]   out_months_elapsed,
  input wire logic [cdd_pkg::DAY_W-1:0]     out_days_elapsed
);

  // any error forces zero counts
  `CDD_ASSERT(a_err_zero, out_valid && (!out_birth_valid || !out_current_valid || out_order_error) |-> (out_years_elapsed == '0) && (out_months_elapsed == '0) && (out_days_elapsed == '0), "counts not zero on error")

  // months and days stay within one year and one month
  `CDD_ASSERT(a_range, out_valid |-> (out_months_elapsed <= 4'd11) && (out_days_elapsed <= 5'd30), "month or day count out of range")

  // a stalled result holds
  `CDD_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_years_elapsed) && $stable(out_months_elapsed) && $stable(out_days_elapsed) && $stable(out_order_error), "stalled result changed")

  // reset empties the result register
  `CDD_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind calendar_date_difference cdd_checker u_cdd_checker (.*);

`default_nettype wire

// File: tb/sv/cdd_date_checker.sv
// checker for calendar_date_difference: watches both channels, predicts each result
// from the accepted date pair and compares it field by field; depends on cdd_pkg

module cdd_date_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [cdd_pkg::DAY_W-1:0]     in_birth_day,
  input  logic [cdd_pkg::MONTH_W-1:0]   in_birth_month,
  input  logic [cdd_pkg::YEAR_W-1:0]    in_birth_year,
  input  logic [cdd_pkg::DAY_W-1:0]     in_current_day,
  input  logic [cdd_pkg::MONTH_W-1:0]   in_current_month,
  input  logic [cdd_pkg::YEAR_W-1:0]    in_current_year,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_birth_valid,
  input  logic                          out_current_valid,
  input  logic                          out_order_error,
  input  logic [cdd_pkg::YEAR_W-1:0]    out_years_elapsed,
  input  logic [cdd_pkg::MONTH_W-1:0]   out_months_elapsed,
  input  logic [cdd_pkg::DAY_W-1:0]     out_days_elapsed,
  output int                            pairs_seen,
  output int                            results_seen,
  output int                            failures
);
  import cdd_pkg::*;

  localparam int MAX_PRINTED = 30;

  typedef struct packed {
    logic               birth_ok;
    logic               current_ok;
    logic               late;
    logic [YEAR_W-1:0]  years;
    logic [MONTH_W-1:0] months;
    logic [DAY_W-1:0]   days;
  } age_result_t;

  age_result_t age_queue[$];
  int          mismatch_count = 0;

  assign failures = mismatch_count;

  // month length with the gregorian leap rule
  function automatic int unsigned month_days(logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
    bit leap;
    leap = (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
    case (m)
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: return 31;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
      MON_FEB: return leap ? 29 : 28;
      default: return 0;
    endcase
  endfunction

  function automatic bit calendar_ok(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                     logic [YEAR_W-1:0] y);
    return (y != 0) && (m >= MON_JAN) && (m <= MON_DEC) && (d >= 1) &&
           (d <= month_days(m, y));
  endfunction

  // expected age for one date pair; counts stay zero on any error
  function automatic age_result_t predict_age(
    logic [DAY_W-1:0] bd, logic [MONTH_W-1:0] bm, logic [YEAR_W-1:0] by,
    logic [DAY_W-1:0] cd, logic [MONTH_W-1:0] cm, logic [YEAR_W-1:0] cy);
    age_result_t r;
    int unsigned mon;
    bit          day_short;
    bit          year_short;
    r            = '0;
    r.birth_ok   = calendar_ok(bd, bm, by);
    r.current_ok = calendar_ok(cd, cm, cy);
    // order compares the raw fields, valid or not
    r.late       = {by, bm, bd} > {cy, cm, cd};
    if (r.birth_ok && r.current_ok && !r.late) begin
      day_short  = cd < bd;
      year_short = (cm < bm) || ((cm == bm) && day_short);
      mon = year_short ? int'(MONTHS_PER_YEAR) + int'(cm) - int'(bm) : int'(cm) - int'(bm);
      r.years = year_short ? int'(cy) - int'(by) - 1 : int'(cy) - int'(by);
      if (day_short) begin
        // month not complete: rest of the birth month plus the current day
        r.months = mon - 1;
        r.days   = month_days(bm, by) - int'(bd) + int'(cd);
      end else begin
        r.months = mon;
        r.days   = int'(cd) - int'(bd);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch at result %0d on %s: got %0d, expected %0d",
               results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(string what, int unsigned got, int unsigned want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // result transfers are compared first, then the new pair is predicted
  always @(posedge clk) begin : watch
    age_result_t want;
    if (!rst_n) begin
      pairs_seen   <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (age_queue.size() == 0) begin
          report_mismatch("result with no pair waiting", 1, 0);
        end else begin
          want = age_queue.pop_front();
          check_field("birth_valid", out_birth_valid, want.birth_ok);
          check_field("current_valid", out_current_valid, want.current_ok);
          check_field("order_error", out_order_error, want.late);
          check_field("years_elapsed", out_years_elapsed, want.years);
          check_field("months_elapsed", out_months_elapsed, want.months);
          check_field("days_elapsed", out_days_elapsed, want.days);
        end
      end
      if (in_valid && !in_stall) begin
        pairs_seen <= pairs_seen + 1;
        age_queue.push_back(predict_age(in_birth_day, in_birth_month, in_birth_year,
                                        in_current_day, in_current_month,
                                        in_current_year));
      end
    end
  end

endmodule

// File: tb/sv/tb_calendar_date_difference.sv
// top of the calendar_date_difference testbench: clock, reset, date pair stimulus,
// receiver stalls and the verdict; depends on cdd_pkg and cdd_date_checker

module tb_calendar_date_difference;
  import cdd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_PAIRS = 1450;
  localparam int DRAIN_CYCLES = 8;

  // month codes outside the calendar
  localparam logic [MONTH_W-1:0] MON_NONE = 4'd0;
  localparam logic [MONTH_W-1:0] MON_BAD  = 4'd13;
  localparam logic [MONTH_W-1:0] MON_TOP  = 4'd15;
  localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd16383;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [DAY_W-1:0]    in_birth_day;
  logic [MONTH_W-1:0]  in_birth_month;
  logic [YEAR_W-1:0]   in_birth_year;
  logic [DAY_W-1:0]    in_current_day;
  logic [MONTH_W-1:0]  in_current_month;
  logic [YEAR_W-1:0]   in_current_year;
  logic                out_valid;
  logic                out_stall;
  logic                out_birth_valid;
  logic                out_current_valid;
  logic                out_order_error;
  logic [YEAR_W-1:0]   out_years_elapsed;
  logic [MONTH_W-1:0]  out_months_elapsed;
  logic [DAY_W-1:0]    out_days_elapsed;
  int                  pairs_seen;
  int                  results_seen;
  int                  failures;

  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  cycle_count   = 0;

  calendar_date_difference dut (.*);
  cdd_date_checker date_check (.*);

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[calendar_date_difference] ERROR");
      $finish;
    end
  end

  // receiver stalls at the current rate
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // one pair transfer, with an optional sender gap ahead of it
  task automatic send_pair(logic [DAY_W-1:0] bd, logic [MONTH_W-1:0] bm,
                           logic [YEAR_W-1:0] by, logic [DAY_W-1:0] cd,
                           logic [MONTH_W-1:0] cm, logic [YEAR_W-1:0] cy);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_birth_day     <= bd;
    in_birth_month   <= bm;
    in_birth_year    <= by;
    in_current_day   <= cd;
    in_current_month <= cm;
    in_current_year  <= cy;
    in_valid         <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pairs_seen != results_seen) @(posedge clk);
  endtask

  // years weighted toward small values, century years, the top of the range and 1896 to 2104
  function automatic logic [YEAR_W-1:0] pick_year();
    case ($urandom_range(0, 4))
      0: return $urandom_range(1, 3);
      1: return 100 * $urandom_range(1, 163);
      2: return $urandom_range(1, YEAR_MAX);
      3: return $urandom_range(YEAR_MAX - 3, YEAR_MAX);
      default: return $urandom_range(1896, 2104);
    endcase
  endfunction

  function automatic logic [DAY_W-1:0] pick_day();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 28);
  endfunction

  function automatic logic [MONTH_W-1:0] bad_month();
    case ($urandom_range(0, 2))
      0: return MON_NONE;
      1: return $urandom_range(MON_BAD, MON_TOP);
      default: return MON_TOP;
    endcase
  endfunction

  // mostly ordered pairs of plausible dates, some noise and some broken pairs
  task automatic random_pair();
    logic [DAY_W-1:0]   bd, cd, td;
    logic [MONTH_W-1:0] bm, cm, tm;
    logic [YEAR_W-1:0]  by, cy, ty;
    int unsigned        kind;
    int unsigned        later;
    kind = $urandom_range(0, 99);
    by   = pick_year();
    bm   = $urandom_range(MON_JAN, MON_DEC);
    bd   = pick_day();
    case ($urandom_range(0, 3))
      0: later = by;
      1: later = by + $urandom_range(0, 5);
      2: later = pick_year();
      default: later = by + 1;
    endcase
    cy = (later > YEAR_MAX) ? YEAR_MAX : later;
    cm = ($urandom_range(0, 3) == 0) ? bm : $urandom_range(MON_JAN, MON_DEC);
    cd = ($urandom_range(0, 7) == 0) ? bd : pick_day();
    if ({by, bm, bd} > {cy, cm, cd}) begin
      {ty, tm, td} = {by, bm, bd};
      {by, bm, bd} = {cy, cm, cd};
      {cy, cm, cd} = {ty, tm, td};
    end
    if (kind < 15) begin
      // raw noise over the full field ranges
      bd = $urandom; bm = $urandom; by = $urandom;
      cd = $urandom; cm = $urandom; cy = $urandom;
    end else if (kind < 30) begin
      case ($urandom_range(0, 6))
        0: bm = bad_month();
        1: cm = bad_month();
        2: bd = '0;
        3: cd = '0;
        4: by = '0;
        5: cy = '0;
        default: begin
          {ty, tm, td} = {by, bm, bd};
          {by, bm, bd} = {cy, cm, cd};
          {cy, cm, cd} = {ty, tm, td};
        end
      endcase
    end
    send_pair(bd, bm, by, cd, cm, cy);
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_birth_day     <= '0;
    in_birth_month   <= '0;
    in_birth_year    <= '0;
    in_current_day   <= '0;
    in_current_month <= '0;
    in_current_year  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 64;

    // directed pairs: equal dates, leap days, invalid fields, order, extremes
    send_pair(5'd1, MON_JAN, 14'd2000, 5'd1, MON_JAN, 14'd2000);
    send_pair(5'd29, MON_FEB, 14'd2000, 5'd28, MON_FEB, 14'd2024);
    send_pair(5'd29, MON_FEB, 14'd1900, 5'd1, MON_MAR, 14'd1900);
    send_pair(5'd29, MON_FEB, 14'd2004, 5'd1, MON_MAR, 14'd2004);
    send_pair(5'd29, MON_FEB, 14'd2003, 5'd1, MON_MAR, 14'd2003);
    send_pair(5'd28, MON_FEB, 14'd2100, 5'd29, MON_FEB, 14'd2400);
    send_pair(5'd0, MON_MAY, 14'd2010, 5'd1, MON_JUN, 14'd2010);
    send_pair(5'd31, MON_APR, 14'd2010, 5'd1, MON_MAY, 14'd2010);
    send_pair(5'd1, MON_NONE, 14'd2010, 5'd1, MON_MAY, 14'd2011);
    send_pair(5'd1, MON_BAD, 14'd2010, 5'd1, MON_MAY, 14'd2011);
    send_pair(5'd1, MON_TOP, 14'd2010, 5'd1, MON_MAY, 14'd2011);
    send_pair(5'd1, MON_JAN, 14'd0, 5'd1, MON_JAN, 14'd5);
    send_pair(5'd1, MON_JAN, 14'd2011, 5'd1, MON_JAN, 14'd2010);
    send_pair(5'd1, MON_JUN, 14'd2010, 5'd1, MON_MAY, 14'd2010);
    send_pair(5'd2, MON_MAY, 14'd2010, 5'd1, MON_MAY, 14'd2010);
    send_pair(5'd31, MON_DEC, YEAR_MAX, 5'd31, MON_DEC, YEAR_MAX);
    send_pair(5'd1, MON_JAN, 14'd1, 5'd31, MON_DEC, YEAR_MAX);
    send_pair(5'd31, MON_DEC, 14'd1999, 5'd1, MON_JAN, 14'd2000);
    send_pair(5'd10, MON_MAY, 14'd2001, 5'd20, MON_MAR, 14'd2003);
    send_pair(5'd25, MON_MAR, 14'd2020, 5'd5, MON_APR, 14'd2020);
    send_pair(5'd31, MON_JAN, 14'd2001, 5'd30, MON_MAR, 14'd2001);
    send_pair(5'd1, MON_JAN, 14'd2001, 5'd31, MON_DEC, 14'd2001);
    send_pair(5'd31, MON_TOP, YEAR_MAX, 5'd31, MON_TOP, YEAR_MAX);
    send_pair(5'd31, MON_TOP, YEAR_MAX, 5'd0, MON_NONE, 14'd0);
    send_pair(5'd0, MON_NONE, 14'd0, 5'd0, MON_NONE, 14'd0);
    drain();

    // random pairs under three idle mixes, sender held back between them
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 12; recv_idle_pct = 64; end
        1: begin send_idle_pct = 64; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int i = 0; i < RANDOM_PAIRS / 3; i++) random_pair();
      drain();
    end

    // let the pipeline settle, then give the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d date pairs and %0d checked results", pairs_seen, results_seen);
    $display("idle mixes sender/receiver: 12/64, 64/12 and none; %0d mismatches", failures);
    if (failures == 0 && pairs_seen == results_seen) begin
      $display("[calendar_date_difference] OK");
    end else begin
      $display("[calendar_date_difference] ERROR");
    end
    $finish;
  end

endmodule
